// File: sv/sslm_pkg.sv
// shared types and codes for the sorted site list merge
`default_nettype none
package sslm_pkg;

   localparam int POS_WIDTH    = 32;
   localparam int ALLELE_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_POP    = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] SRC_A    = 2'd0;
   localparam logic [1:0] SRC_B    = 2'd1;
   localparam logic [1:0] SRC_BOTH = 2'd2;

   // word index of the merge_equal register
   localparam logic CSR_IDX_MERGE_EQUAL = 1'b0;

   typedef struct packed {
      logic [1:0]              mode;
      logic [POS_WIDTH-1:0]    position;
      logic [ALLELE_WIDTH-1:0] alleles;
   } req_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0]    out_position;
      logic [ALLELE_WIDTH-1:0] out_alleles;
      logic [1:0]              source;
      logic                    last;
      logic                    done_res;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic clear;
   } list_ctl_type;

   typedef struct packed {
      logic                    has;
      logic                    has_second;
      logic [POS_WIDTH-1:0]    position;
      logic [ALLELE_WIDTH-1:0] alleles;
   } list_head_type;

endpackage
`default_nettype wire

// File: sv/sslm_list.sv
// one site list: storage, fill count, read pointer and registered head
`default_nettype none
module sslm_list
   import sslm_pkg::*;
#(
   parameter int LIST_DEPTH  = 64,
   parameter int ALLELE_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire list_ctl_type            ctl,
   input  wire logic [POS_WIDTH-1:0]    wr_position,
   input  wire logic [ALLELE_WIDTH-1:0] wr_alleles,
   output      list_head_type           head
);

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [POS_WIDTH-1:0]   pos_mem [LIST_DEPTH];
   logic [ALLELE_BITS-1:0] all_mem [LIST_DEPTH];

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       read_ff, read_in;
   logic [POS_WIDTH-1:0]   head_pos_ff;
   logic [ALLELE_BITS-1:0] head_all_ff;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;

   assign wr_en   = ctl.load && (count_ff != CNT_W'(LIST_DEPTH));
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign rd_addr = read_in[ADDR_W-1:0];

   always_comb begin
      count_in = count_ff;
      read_in  = read_ff;
      if (ctl.clear) begin
         count_in = '0;
         read_in  = '0;
      end else begin
         if (wr_en) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (ctl.pop) begin
            read_in = read_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         read_ff  <= '0;
      end else begin
         count_ff <= count_in;
         read_ff  <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr] <= wr_position;
         all_mem[wr_addr] <= wr_alleles[ALLELE_BITS-1:0];
      end
   end

   // head tracks the entry at the read pointer; bypass a load into an empty list
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         head_pos_ff <= wr_position;
         head_all_ff <= wr_alleles[ALLELE_BITS-1:0];
      end else begin
         head_pos_ff <= pos_mem[rd_addr];
         head_all_ff <= all_mem[rd_addr];
      end
   end

   assign head.has        = read_ff < count_ff;
   assign head.has_second = (read_ff < count_ff) && ((count_ff - read_ff) != CNT_W'(1));
   assign head.position   = head_pos_ff;
   assign head.alleles    = ALLELE_WIDTH'(head_all_ff);

endmodule
`default_nettype wire

// File: sv/sslm_csr.sv
// configuration register file with the merge_equal control bit
`default_nettype none
module sslm_csr
   import sslm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready,
   output      logic                      merge_equal
);

   logic merge_equal_ff, merge_equal_in;
   logic hit;

   // byte offset bits are ignored
   assign hit = (paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_MERGE_EQUAL);

   always_comb begin
      merge_equal_in = merge_equal_ff;
      if (psel && penable && pwrite && hit) begin
         merge_equal_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_equal_ff <= 1'b0;
      end else begin
         merge_equal_ff <= merge_equal_in;
      end
   end

   assign prdata      = hit ? CSR_DATA_WIDTH'(merge_equal_ff) : '0;
   assign pready      = 1'b1;
   assign merge_equal = merge_equal_ff;

endmodule
`default_nettype wire

// File: sv/sorted_site_list_merge_top.sv
// top level of the two-way sorted site list merge
`default_nettype none
// Two site lists, A and B, are loaded word by word and popped in merged order, lower position
// first and A first on a tie; with merge_equal set, equal heads fuse into one site with ORed
// allele bits. A new request word (load, pop or clear) can be accepted on every cycle; a
// pop's result appears in the output register on the cycle after
// acceptance. The rate is set by the per-list head registers, which the synchronous memory
// read refreshes at the next read pointer every cycle, with a bypass for a load that lands
// on the head entry. req_ready is low only while a result waits and rsp_ready is low. There
// is no clearing pass after reset: list storage is used only behind the fill counts.
module sorted_site_list_merge_top
   import sslm_pkg::*;
#(
   parameter int LIST_DEPTH = 64,
   parameter int HAPLOTYPES = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire req_type                   req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      rsp_type                   rsp_data,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready
);

   localparam int ALLELE_BITS = (HAPLOTYPES >= ALLELE_WIDTH) ? ALLELE_WIDTH : HAPLOTYPES;

   logic          merge_equal;
   list_ctl_type  ctl_a, ctl_b;
   list_head_type head_a, head_b;
   logic          accept;
   logic          pop_fire;
   logic          take_a;
   logic          fuse;
   rsp_type       result;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   sslm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .merge_equal (merge_equal)
   );

   sslm_list #(
      .LIST_DEPTH  (LIST_DEPTH),
      .ALLELE_BITS (ALLELE_BITS)
   ) u_list_a (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_a),
      .wr_position (req_data.position),
      .wr_alleles  (req_data.alleles),
      .head        (head_a)
   );

   sslm_list #(
      .LIST_DEPTH  (LIST_DEPTH),
      .ALLELE_BITS (ALLELE_BITS)
   ) u_list_b (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_b),
      .wr_position (req_data.position),
      .wr_alleles  (req_data.alleles),
      .head        (head_b)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pop_fire  = accept && (req_data.mode == MODE_POP);

   // head compare: A wins when it holds a site, unless B is strictly lower
   assign take_a = head_a.has && !(head_b.has && (head_b.position < head_a.position));
   assign fuse   = take_a && merge_equal && head_b.has && (head_b.position == head_a.position);

   always_comb begin
      ctl_a.load  = accept && (req_data.mode == MODE_LOAD_A);
      ctl_b.load  = accept && (req_data.mode == MODE_LOAD_B);
      ctl_a.clear = accept && (req_data.mode == MODE_CLEAR);
      ctl_b.clear = accept && (req_data.mode == MODE_CLEAR);
      ctl_a.pop   = pop_fire && take_a;
      ctl_b.pop   = pop_fire && head_b.has && (!take_a || fuse);
   end

   always_comb begin
      result = '0;
      priority if (!head_a.has && !head_b.has) begin
         result.done_res = 1'b1;
      end else if (fuse) begin
         result.out_position = head_a.position;
         result.out_alleles  = head_a.alleles | head_b.alleles;
         result.source       = SRC_BOTH;
         result.last         = !head_a.has_second && !head_b.has_second;
      end else if (take_a) begin
         result.out_position = head_a.position;
         result.out_alleles  = head_a.alleles;
         result.source       = SRC_A;
         result.last         = !head_a.has_second && !head_b.has;
      end else begin
         result.out_position = head_b.position;
         result.out_alleles  = head_b.alleles;
         result.source       = SRC_B;
         result.last         = !head_a.has && !head_b.has_second;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // done word carries nothing else
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |->
         rsp_data_ff.out_position == '0 && rsp_data_ff.out_alleles == '0 &&
         rsp_data_ff.source == SRC_A && !rsp_data_ff.last)
      else $error("done word with nonzero payload");

   a_source_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.source != 2'd3)
      else $error("illegal source code");

   // a pop with a site available never reports done
   a_pop_not_done: assert property (@(posedge clock) disable iff (reset)
      pop_fire && (head_a.has || head_b.has) |=> rsp_valid_ff && !rsp_data_ff.done_res)
      else $error("pop reported done while a site was available");

   a_fuse_both: assert property (@(posedge clock) disable iff (reset)
      pop_fire && fuse |-> ctl_a.pop && ctl_b.pop)
      else $error("fused site did not advance both lists");

endmodule
`default_nettype wire

// File: bench/testbench.sv
// testbench for the sorted site list merge: directed table, random load/pop sequences, csr sweep
module testbench
   import sslm_pkg::*;
();

   localparam int SITE_DEPTH = 64;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MERGE_EQUAL = {CSR_IDX_MERGE_EQUAL, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNUSED = 3'd4;
   localparam rsp_type DONE_SITE = '{32'h0, 32'h0, SRC_A, 1'b0, 1'b1};
   localparam rsp_type NO_SITE = '0;

   typedef struct {
      bit                        do_csr;
      logic [CSR_ADDR_WIDTH-1:0] csr_addr;
      logic [31:0]               csr_val;
      logic [1:0]                mode;
      logic [31:0]               position;
      logic [31:0]               alleles;
      bit                        fixed;
      rsp_type                   want;
   } stim_row;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   // predictor copy of the block state
   logic [31:0] a_pos [SITE_DEPTH];
   logic [31:0] a_all [SITE_DEPTH];
   logic [31:0] b_pos [SITE_DEPTH];
   logic [31:0] b_all [SITE_DEPTH];
   int unsigned a_count = 0;
   int unsigned b_count = 0;
   int unsigned a_read = 0;
   int unsigned b_read = 0;
   bit fuse_equal = 0;

   rsp_type pending_sites [$];
   int unsigned words_sent = 0;
   int unsigned sites_checked = 0;
   int unsigned fused_sites = 0;
   int unsigned empty_pops = 0;
   int unsigned dropped_loads = 0;
   int unsigned csr_writes = 0;
   int unsigned errors = 0;
   bit no_idle = 0;

   stim_row directed_rows [28] = '{
      '{1, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1, DONE_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_A, 32'h0, 32'h0, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h0, 32'hffff_ffff, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_A, 32'h8000_0000, 32'haaaa_aaaa, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'hffff_ffff, 32'h5555_5555, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1,
        '{32'h0, 32'h0, SRC_A, 1'b0, 1'b0}},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1,
        '{32'h0, 32'hffff_ffff, SRC_B, 1'b0, 1'b0}},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1,
        '{32'h8000_0000, 32'haaaa_aaaa, SRC_A, 1'b0, 1'b0}},
      // lands at the head of the emptied A list, below what was already emitted
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_A, 32'h7fff_ffff, 32'h1234_5678, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'hffff_ffff, 32'hffff_ffff, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1,
        '{32'hffff_ffff, 32'h5555_5555, SRC_B, 1'b1, 1'b0}},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1, DONE_SITE},
      '{1, ADDR_MERGE_EQUAL, 32'd1, MODE_LOAD_A, 32'h4000_0000, 32'hf0f0_f0f0, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h4000_0000, 32'h0f0f_000f, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h4000_0000, 32'h0000_0001, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1,
        '{32'h4000_0000, 32'hffff_f0ff, SRC_BOTH, 1'b0, 1'b0}},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 0, NO_SITE},
      '{1, ADDR_UNUSED, 32'd0, MODE_LOAD_A, 32'h10, 32'h1, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h10, 32'h2, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 1, DONE_SITE},
      // clear and the write to an unused address both leave the fuse setting alone
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_A, 32'h20, 32'h3, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h20, 32'h4, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 0, NO_SITE},
      '{1, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_A, 32'h5, 32'h8, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_LOAD_B, 32'h5, 32'h9, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 0, NO_SITE},
      '{0, ADDR_MERGE_EQUAL, 32'd0, MODE_POP, 32'h0, 32'h0, 0, NO_SITE}
   };

   sorted_site_list_merge_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic string site_str(input rsp_type s);
      return $sformatf("pos=%h alleles=%h src=%0d last=%0b done=%0b",
                       s.out_position, s.out_alleles, s.source, s.last, s.done_res);
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("error: %s", msg);
   endtask

   function automatic int pick_gap();
      return no_idle ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic req_type make_word(input logic [1:0] mode, input logic [31:0] pos,
                                         input logic [31:0] all);
      req_type w;
      w.mode = mode;
      w.position = pos;
      w.alleles = all;
      return w;
   endfunction

   // advances the predictor by one word; returns 1 when the word yields a site
   function automatic bit merge_next_site(input req_type w, output rsp_type site);
      bit has_a;
      bit has_b;
      bit take_a;
      site = '0;
      case (w.mode)
         MODE_LOAD_A: begin
            if (a_count < SITE_DEPTH) begin
               a_pos[a_count] = w.position;
               a_all[a_count] = w.alleles;
               a_count++;
            end else begin
               dropped_loads++;
            end
            return 0;
         end
         MODE_LOAD_B: begin
            if (b_count < SITE_DEPTH) begin
               b_pos[b_count] = w.position;
               b_all[b_count] = w.alleles;
               b_count++;
            end else begin
               dropped_loads++;
            end
            return 0;
         end
         MODE_CLEAR: begin
            a_count = 0;
            b_count = 0;
            a_read = 0;
            b_read = 0;
            return 0;
         end
         default: begin
         end
      endcase
      has_a = a_read < a_count;
      has_b = b_read < b_count;
      if (!has_a && !has_b) begin
         site.done_res = 1'b1;
         empty_pops++;
         return 1;
      end
      take_a = has_a && !(has_b && b_pos[b_read] < a_pos[a_read]);
      if (take_a) begin
         site.out_position = a_pos[a_read];
         site.out_alleles = a_all[a_read];
         site.source = SRC_A;
         if (fuse_equal && has_b && b_pos[b_read] == a_pos[a_read]) begin
            site.out_alleles = site.out_alleles | b_all[b_read];
            site.source = SRC_BOTH;
            b_read++;
            fused_sites++;
         end
         a_read++;
      end else begin
         site.out_position = b_pos[b_read];
         site.out_alleles = b_all[b_read];
         site.source = SRC_B;
         b_read++;
      end
      site.last = (a_read >= a_count) && (b_read >= b_count);
      return 1;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input req_type w, input bit fixed, input rsp_type want);
      int gap;
      bit yields;
      rsp_type site;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      yields = merge_next_site(w, site);
      if (yields) pending_sites.insert(pending_sites.size(), fixed ? want : site);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_sites.size() != 0) @(negedge clock);
      // loads and clears give no result, so let the pipeline drain
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] value);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MERGE_EQUAL) fuse_equal = value[0];
      csr_writes++;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= ADDR_MERGE_EQUAL;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {31'b0, fuse_equal})
         flag_error($sformatf("merge_equal readback: want %h got %h",
                              {31'b0, fuse_equal}, prdata));
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [31:0] draw_position(input int style);
      case (style)
         0: return $urandom_range(0, 32'h8000_0000);
         1: return $urandom_range(0, 8) << 28;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] draw_alleles();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // clear, fill both lists in random interleave (sorted unless style 3), then pop past the end
   task automatic load_and_drain();
      int style;
      int na;
      int nb;
      int pops;
      logic [31:0] pa [$];
      logic [31:0] pb [$];
      bit pick_a;
      style = $urandom_range(0, 3);
      na = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
      nb = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
      for (int i = 0; i < na; i++) pa.insert(pa.size(), draw_position(style));
      for (int i = 0; i < nb; i++) pb.insert(pb.size(), draw_position(style));
      // style 3 keeps the lists unsorted
      if (style != 3) begin
         pa.sort();
         pb.sort();
      end
      send_word(make_word(MODE_CLEAR, $urandom(), $urandom()), 0, NO_SITE);
      while (pa.size() + pb.size() > 0) begin
         if ($urandom_range(0, 9) == 0)
            send_word(make_word(MODE_POP, $urandom(), $urandom()), 0, NO_SITE);
         pick_a = pb.size() == 0 || (pa.size() > 0 && $urandom_range(0, 1) == 1);
         if (pick_a)
            send_word(make_word(MODE_LOAD_A, pa.pop_front(), draw_alleles()), 0, NO_SITE);
         else
            send_word(make_word(MODE_LOAD_B, pb.pop_front(), draw_alleles()), 0, NO_SITE);
      end
      pops = na + nb + $urandom_range(1, 2);
      repeat (pops) send_word(make_word(MODE_POP, $urandom(), $urandom()), 0, NO_SITE);
   endtask

   task automatic send_noise();
      logic [1:0] mode;
      repeat ($urandom_range(4, 12)) begin
         mode = 2'($urandom_range(0, 3));
         send_word(make_word(mode, draw_position($urandom_range(0, 2)), draw_alleles()),
                   0, NO_SITE);
      end
   endtask

   // result side: random stalls, every word checked against the oldest expectation
   initial begin
      rsp_type want;
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (pending_sites.size() == 0) begin
            flag_error($sformatf("unexpected site %s", site_str(rsp_data)));
         end else begin
            want = pending_sites.pop_front();
            sites_checked++;
            if (rsp_data.out_position !== want.out_position ||
                rsp_data.out_alleles !== want.out_alleles ||
                rsp_data.source !== want.source ||
                rsp_data.last !== want.last ||
                rsp_data.done_res !== want.done_res)
               flag_error($sformatf("want %s got %s", site_str(want), site_str(rsp_data)));
         end
         @(negedge clock);
      end
   end

   initial begin
      int directed_count;
      int phase_end;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].do_csr)
            write_csr(directed_rows[i].csr_addr, directed_rows[i].csr_val);
         send_word(make_word(directed_rows[i].mode, directed_rows[i].position,
                             directed_rows[i].alleles),
                   directed_rows[i].fixed, directed_rows[i].want);
      end
      directed_count = words_sent;

      for (int phase = 0; words_sent < directed_count + 500; phase++) begin
         no_idle = 1'b0;
         write_csr(ADDR_MERGE_EQUAL, (phase == 0) ? 32'd1 :
                                     (phase == 1) ? 32'd0 : $urandom_range(0, 1));
         if ($urandom_range(0, 2) == 0) write_csr(ADDR_UNUSED, $urandom());
         phase_end = words_sent + 100;
         while (words_sent < phase_end) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) load_and_drain();
            else send_noise();
         end
      end

      no_idle = 1'b0;
      wait_idle();
      repeat (8) @(posedge clock);
      $display("summary: %0d words, %0d sites checked, %0d fused, %0d pops on empty lists",
               words_sent, sites_checked, fused_sites, empty_pops);
      $display("summary: %0d loads dropped on full lists, %0d register writes, %0d errors",
               dropped_loads, csr_writes, errors);
      if (errors == 0) begin
         $display("sorted_site_list_merge_top: match");
      end else begin
         $display("sorted_site_list_merge_top: mismatch");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout");
      $display("sorted_site_list_merge_top: mismatch");
      $finish;
   end

endmodule
